[hdl/arvd_pkg.sv]
// ----------------------------------------------------------------------------
// arvd_pkg
// Shared types and constants for the analog range voltage-to-distance block.
// ----------------------------------------------------------------------------
package arvd_pkg;

	// Field widths
	localparam int RANGE_BITS    = 20;
	localparam int SAMPLE_BITS   = 16;
	localparam int OFFSET_BITS   = 16;
	localparam int SCALE_BITS    = 24;
	localparam int MAXR_BITS     = 15;
	localparam int CFG_DATA_BITS = 24;

	// Datapath widths
	localparam int DV_BITS    = SAMPLE_BITS + 2;          // signed voltage difference
	localparam int MAG_BITS   = SAMPLE_BITS + 1;          // |difference| / divisor
	localparam int OPND_BITS  = 20;                       // multiplier operand
	localparam int PROD_BITS  = OPND_BITS + SCALE_BITS;
	localparam int FRAC_BITS  = 16;                       // fraction bits of the Q8.16 scale
	localparam int QUOT_BITS  = PROD_BITS - FRAC_BITS;    // dividend and quotient
	localparam int CAP_BITS   = MAXR_BITS + 4;            // max_range_cm * 10

	// Divider pipeline: two quotient bits per stage
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = QUOT_BITS / DIV_STEPS;

	// Accept edge to result edge, in clock cycles
	localparam int LATENCY = DIV_STAGES + 3;

	// Constants of the conversion
	localparam logic [OPND_BITS-1:0] HYPER_NUM = OPND_BITS'(1000000);
	localparam logic [CAP_BITS-1:0]  CM_TO_MM  = CAP_BITS'(10);
	localparam logic [QUOT_BITS-1:0] SAT_MAX   = QUOT_BITS'((64'd1 << RANGE_BITS) - 64'd1);

	// Reset values of the registers
	localparam logic [SCALE_BITS-1:0] SCALE_RST = SCALE_BITS'(196608);
	localparam logic [MAXR_BITS-1:0]  MAXR_RST  = MAXR_BITS'(700);

	typedef enum logic [1:0] {
		MODE_LINEAR    = 2'd0,
		MODE_INVERTED  = 2'd1,
		MODE_HYPERBOLA = 2'd2
	} curve_mode_t;

	typedef enum logic [1:0] {
		CFG_CURVE_MODE   = 2'd0,
		CFG_OFFSET_MV    = 2'd1,
		CFG_SCALE_Q16    = 2'd2,
		CFG_MAX_RANGE_CM = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample_mv;
		logic                   channel_ok;
	} sample_t;

	typedef struct packed {
		logic [RANGE_BITS-1:0] range_mm;
		logic                  at_limit;
	} range_t;

	// Side-band that rides along with each word through the divider
	typedef struct packed {
		logic hyper;      // apply max-range clamp instead of saturation
		logic force_lim;  // floor was applied upstream
	} div_tag_t;

endpackage

[hdl/arvd_div.sv]
// ----------------------------------------------------------------------------
// arvd_div
// Pipelined restoring divider, two quotient bits per stage, one word per cycle.
// ----------------------------------------------------------------------------
module arvd_div
	import arvd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [QUOT_BITS-1:0] in_num,
	input  logic [MAG_BITS-1:0]  in_den,
	input  div_tag_t             in_tag,
	output logic                 out_valid,
	output logic [QUOT_BITS-1:0] out_quot,
	output div_tag_t             out_tag
);

	// Index 0 is the input side; index g+1 is the register after stage g.
	logic                 vld_s [0:DIV_STAGES];
	logic [MAG_BITS-1:0]  rem_s [0:DIV_STAGES];
	logic [QUOT_BITS-1:0] nq_s  [0:DIV_STAGES];
	logic [MAG_BITS-1:0]  den_s [0:DIV_STAGES];
	div_tag_t             tag_s [0:DIV_STAGES];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign nq_s[0]  = in_num;
	assign den_s[0] = in_den;
	assign tag_s[0] = in_tag;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [MAG_BITS-1:0]  rem_nx;
		logic [QUOT_BITS-1:0] nq_nx;

		// Per step, shift in the next dividend bit, subtract when it fits, shift in a quotient bit
		always_comb begin
			logic [MAG_BITS:0] trial;
			logic              qbit;
			rem_nx = rem_s[g];
			nq_nx  = nq_s[g];
			for (int k = 0; k < DIV_STEPS; k++) begin
				trial = {rem_nx, nq_nx[QUOT_BITS-1]};
				qbit  = 1'b0;
				if (trial >= {1'b0, den_s[g]}) begin
					trial = trial - {1'b0, den_s[g]};
					qbit  = 1'b1;
				end
				rem_nx = trial[MAG_BITS-1:0];
				nq_nx  = {nq_nx[QUOT_BITS-2:0], qbit};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= rem_nx;
			nq_s[g+1]  <= nq_nx;
			den_s[g+1] <= den_s[g];
			tag_s[g+1] <= tag_s[g];
		end
	end

	assign out_valid = vld_s[DIV_STAGES];
	assign out_quot  = nq_s[DIV_STAGES];
	assign out_tag   = tag_s[DIV_STAGES];

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> in_den != '0)
		else $error("divider fed a zero divisor");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIV_STAGES] |-> rem_s[DIV_STAGES] < den_s[DIV_STAGES])
		else $error("final remainder not below divisor");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##DIV_STAGES out_valid)
		else $error("word lost in divider pipeline");

endmodule

[hdl/analog_range_voltage_to_distance.sv]
// ----------------------------------------------------------------------------
// analog_range_voltage_to_distance
// Converts an averaged rangefinder voltage (mV) to a distance (mm).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive a word on item and raise start. The word is taken
//   at every rising edge where start is high and busy is low. busy never
//   rises: the pipeline takes a new word on every cycle.
//   Output channel: each word gives one result on result, marked by done for
//   exactly one cycle. The receiver cannot stall and must take it then.
//   Pipeline: one register stage for the voltage difference, one for the
//   multiplier, fourteen for the divider (two quotient bits each) and one
//   for clamp and saturation.
//   Throughput: one word per cycle, set by the fully pipelined divider.
//   Configuration: cfg_we writes cfg_data into the register picked by
//   cfg_idx at that edge. Write only while no words are in flight.
//   Reset: arst_n clears all valid bits and loads the register defaults
//   (linear curve, zero offset, scale 3.0, max range 700 cm).
//   Curves: linear and inverted run dv*scale/65536 through the divider with a
//   divisor of one; the hyperbola runs scale*1e6/65536 divided by dv.
// ----------------------------------------------------------------------------
module analog_range_voltage_to_distance
	import arvd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  sample_t                  item,
	input  logic                     cfg_we,
	input  cfg_idx_t                 cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output logic                     done,
	output range_t                   result
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	curve_mode_t                    curve_mode_q;
	logic signed [OFFSET_BITS-1:0]  offset_mv_q;
	logic [SCALE_BITS-1:0]          scale_q16_q;
	logic [MAXR_BITS-1:0]           max_range_cm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_mode_q   <= MODE_LINEAR;
			offset_mv_q    <= '0;
			scale_q16_q    <= SCALE_RST;
			max_range_cm_q <= MAXR_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_CURVE_MODE: begin
					curve_mode_q <= curve_mode_t'(cfg_data[1:0]);
				end
				CFG_OFFSET_MV: begin
					offset_mv_q <= $signed(cfg_data[OFFSET_BITS-1:0]);
				end
				CFG_SCALE_Q16: begin
					scale_q16_q <= cfg_data[SCALE_BITS-1:0];
				end
				CFG_MAX_RANGE_CM: begin
					max_range_cm_q <= cfg_data[MAXR_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The pipeline never backs up, so a word is taken on every start.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ------------------------------------------------------------------
	// Stage 1: effective voltage and signed difference
	// ------------------------------------------------------------------
	logic signed [DV_BITS-1:0] v_ext;
	logic signed [DV_BITS-1:0] off_ext;
	logic signed [DV_BITS-1:0] dv_in;

	always_comb begin
		// unconnected channel reads as 0 mV
		v_ext   = item.channel_ok ? $signed({2'b00, item.sample_mv}) : '0;
		off_ext = $signed({{(DV_BITS-OFFSET_BITS){offset_mv_q[OFFSET_BITS-1]}}, offset_mv_q});
		if (curve_mode_q == MODE_INVERTED) begin
			dv_in = off_ext - v_ext;
		end else begin
			dv_in = v_ext - off_ext;
		end
	end

	logic                      vld_s1;
	logic signed [DV_BITS-1:0] dv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		dv_s1 <= dv_in;
	end

	// ------------------------------------------------------------------
	// Stage 2: pick operand and divisor per curve, multiply by scale
	// ------------------------------------------------------------------
	logic                  dv_neg;
	logic                  dv_pos;
	logic [MAG_BITS-1:0]   dv_mag;
	logic [OPND_BITS-1:0]  opnd;
	logic [MAG_BITS-1:0]   den_nx;
	div_tag_t              tag_nx;
	logic [PROD_BITS-1:0]  prod;

	always_comb begin
		dv_neg = dv_s1[DV_BITS-1];
		dv_pos = !dv_neg && (dv_s1 != '0);
		dv_mag = dv_s1[MAG_BITS-1:0];
		opnd   = '0;
		den_nx = MAG_BITS'(1);
		tag_nx = '0;
		case (curve_mode_q)
			MODE_LINEAR, MODE_INVERTED: begin
				// floor a negative product at zero; divide by one
				opnd             = dv_neg ? '0 : OPND_BITS'(dv_mag);
				tag_nx.force_lim = dv_neg && (scale_q16_q != '0);
			end
			MODE_HYPERBOLA: begin
				// at or below the offset the result is a plain zero
				opnd         = dv_pos ? HYPER_NUM : '0;
				den_nx       = dv_pos ? dv_mag : MAG_BITS'(1);
				tag_nx.hyper = 1'b1;
			end
			default: begin
			end
		endcase
		prod = PROD_BITS'(opnd) * PROD_BITS'(scale_q16_q);
	end

	logic                 vld_s2;
	logic [QUOT_BITS-1:0] num_s2;
	logic [MAG_BITS-1:0]  den_s2;
	div_tag_t             tag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		num_s2 <= prod[PROD_BITS-1:FRAC_BITS];
		den_s2 <= den_nx;
		tag_s2 <= tag_nx;
	end

	// ------------------------------------------------------------------
	// Divider stages
	// ------------------------------------------------------------------
	logic                 div_vld;
	logic [QUOT_BITS-1:0] div_quot;
	div_tag_t             div_tag;

	arvd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_num    (num_s2),
		.in_den    (den_s2),
		.in_tag    (tag_s2),
		.out_valid (div_vld),
		.out_quot  (div_quot),
		.out_tag   (div_tag)
	);

	// ------------------------------------------------------------------
	// Output stage: max-range clamp (hyperbola) or saturation (linear)
	// ------------------------------------------------------------------
	logic [CAP_BITS-1:0]   cap_mm;
	logic [RANGE_BITS-1:0] mm_nx;
	logic                  lim_nx;

	always_comb begin
		cap_mm = CAP_BITS'(max_range_cm_q) * CM_TO_MM;
		mm_nx  = div_quot[RANGE_BITS-1:0];
		lim_nx = div_tag.force_lim;
		if (div_tag.hyper) begin
			if (div_quot > QUOT_BITS'(cap_mm)) begin
				mm_nx  = RANGE_BITS'(cap_mm);
				lim_nx = 1'b1;
			end
		end else if (div_quot > SAT_MAX) begin
			mm_nx  = SAT_MAX[RANGE_BITS-1:0];
			lim_nx = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		result.range_mm <= mm_nx;
		result.at_limit <= lim_nx;
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("accepted word produced no result");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without a matching accepted word");

	a_hyper_cap: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld && div_tag.hyper |=> result.range_mm <= $past(cap_mm))
		else $error("hyperbola result above max range");

	a_floor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld && div_tag.force_lim |=> result.range_mm == '0 && result.at_limit)
		else $error("floored word not reported as zero at limit");

endmodule
